@@ rtl/core/wsrm_pkg.sv @@
// Shared types and constants for the wildcard star pattern matcher.
package wsrm_pkg;

    localparam int MAX_PATTERN_DEF = 32;
    localparam int POS_W           = 5;
    localparam int SYM_W           = 8;
    localparam int KIND_W          = 2;

    localparam logic [SYM_W-1:0] SYM_STAR = 8'h2A;
    localparam logic [SYM_W-1:0] SYM_DOT  = 8'h2E;

    // Item kinds; the remaining code carries no meaning and is dropped.
    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD = 2'd0,
        KIND_TEXT = 2'd1,
        KIND_END  = 2'd2
    } t_kind;

    typedef enum logic {
        ST_RUN  = 1'b0,
        ST_HOLD = 1'b1
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_dp_cmd;

endpackage

@@ rtl/core/wsrm_ctrl.sv @@
// Controller state machine: input and output handshakes and datapath commands.
module wsrm_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic [wsrm_pkg::KIND_W-1:0]     i_kind,
    input  logic                            i_out_ready,
    output logic                            o_in_ready,
    output logic                            o_out_valid,
    output wsrm_pkg::t_dp_cmd               o_cmd
);
    import wsrm_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_out_valid = (r_state == ST_HOLD);
        // The result register frees up in the same cycle it is taken.
        o_in_ready  = (r_state == ST_RUN) || i_out_ready;
        w_accept    = i_in_valid && o_in_ready;
        o_cmd       = '0;
        unique case (t_kind'(i_kind))
            KIND_LOAD: o_cmd.load   = w_accept;
            KIND_TEXT: o_cmd.step   = w_accept;
            KIND_END:  o_cmd.finish = w_accept;
            default:   o_cmd        = '0;
        endcase
        n_state = r_state;
        priority if (o_cmd.finish) begin
            n_state = ST_HOLD;
        end else if (r_state == ST_HOLD && i_out_ready) begin
            n_state = ST_RUN;
        end
    end

endmodule

@@ rtl/core/wsrm_dp.sv @@
// Datapath: pattern store, prefix match row, star closure and row update.
module wsrm_dp #(
    parameter int MAX_PATTERN = wsrm_pkg::MAX_PATTERN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  wsrm_pkg::t_dp_cmd               i_cmd,
    input  logic [wsrm_pkg::POS_W-1:0]      i_position,
    input  logic [wsrm_pkg::SYM_W-1:0]      i_symbol,
    input  logic                            i_pattern_last,
    output logic                            o_matched
);
    import wsrm_pkg::*;

    localparam int IDX_W  = $clog2(MAX_PATTERN);
    localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int LEVELS = $clog2(MAX_PATTERN);

    logic [SYM_W-1:0]   r_pat [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] r_is_star;
    logic [MAX_PATTERN-1:0] r_is_dot;
    logic [LEN_W-1:0]   r_len;
    logic [MAX_PATTERN:0] r_row;
    logic               r_matched;

    logic [MAX_PATTERN:0]   w_gen [LEVELS+1];
    logic [MAX_PATTERN:0]   w_prop [LEVELS+1];
    logic [MAX_PATTERN:0]   w_closed;
    logic [MAX_PATTERN-1:0] w_hit;
    logic [MAX_PATTERN:0]   w_next_row;
    logic                   w_load_ok;
    logic [IDX_W-1:0]       w_idx;

    assign w_load_ok = i_cmd.load && (int'(i_position) < MAX_PATTERN);
    assign w_idx     = IDX_W'(i_position);

    // Pattern entries carry no reset; star and dot flags are decoded on load.
    always_ff @(posedge i_clk) begin
        if (w_load_ok) begin
            r_pat[w_idx]     <= i_symbol;
            r_is_star[w_idx] <= (i_symbol == SYM_STAR);
            r_is_dot[w_idx]  <= (i_symbol == SYM_DOT);
        end
        if (i_cmd.finish) begin
            r_matched <= w_closed[r_len];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_row <= (MAX_PATTERN+1)'(1);
        end else begin
            if (w_load_ok && i_pattern_last) begin
                r_len <= LEN_W'(i_position) + LEN_W'(1);
            end
            if (i_cmd.finish) begin
                r_row <= (MAX_PATTERN+1)'(1);
            end else if (i_cmd.step) begin
                r_row <= w_next_row;
            end
        end
    end

    // Empty-match closure: e[j] = row[j] | (star at j-1 & e[j-2]), solved as a
    // parallel prefix with strides 2, 4, 8, ... rather than a long ripple.
    always_comb begin
        w_gen[0]  = r_row;
        w_prop[0] = '0;
        for (int j = 2; j <= MAX_PATTERN; j++) begin
            w_prop[0][j] = r_is_star[j-1];
        end
        for (int k = 0; k < LEVELS; k++) begin
            w_gen[k+1]  = w_gen[k];
            w_prop[k+1] = w_prop[k];
            for (int j = 0; j <= MAX_PATTERN; j++) begin
                if (j >= (2 << k)) begin
                    w_gen[k+1][j]  = w_gen[k][j] | (w_prop[k][j] & w_gen[k][j-(2<<k)]);
                    w_prop[k+1][j] = w_prop[k][j] & w_prop[k][j-(2<<k)];
                end
            end
        end
        w_closed = w_gen[LEVELS];
    end

    // Row update for one text character.
    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            w_hit[i] = r_is_dot[i] || (r_pat[i] == i_symbol);
        end
        w_next_row    = '0;
        w_next_row[1] = !r_is_star[0] && w_hit[0] && w_closed[0];
        for (int j = 2; j <= MAX_PATTERN; j++) begin
            if (r_is_star[j-1]) begin
                w_next_row[j] = w_hit[j-2] && w_closed[j];
            end else begin
                w_next_row[j] = w_hit[j-1] && w_closed[j-1];
            end
        end
    end

    assign o_matched = r_matched;

endmodule

@@ rtl/core/wildcard_star_regex_matcher.sv @@
// Top level of the wildcard star pattern matcher.
//
// Whole-string matching of a byte stream against a pattern in which '.'
// stands for any byte and '*' for zero or more of the element before it.
// One input channel carries three kinds of item: a pattern symbol written at
// a position (with a flag marking the last symbol, which sets the length), a
// text character, and an end-of-text mark. Only the end-of-text item gives a
// result: one bit saying whether the whole text matches the whole pattern,
// after which the match row returns to its empty-text value.
// One item per cycle is sustained while no result is stalled; the row update
// and its star closure sit in one register-to-register path through the
// datapath. A result appears on the output in the cycle after its
// end-of-text item was accepted and is held in a result register.
// While a result is held and the receiver stalls, input ready stays low and
// no item of any kind is taken; in the cycle the result is taken a new item
// may enter, so the input is held off for exactly as long as the stall.
// Reset empties the pattern length and the match row; pattern entries are
// not cleared and must be written before use. No clearing pass is needed.
module wildcard_star_regex_matcher #(
    parameter int MAX_PATTERN = wsrm_pkg::MAX_PATTERN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [wsrm_pkg::KIND_W-1:0]     i_kind,
    input  logic [wsrm_pkg::POS_W-1:0]      i_position,
    input  logic [wsrm_pkg::SYM_W-1:0]      i_symbol,
    input  logic                            i_pattern_last,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_matched
);
    import wsrm_pkg::*;

    t_dp_cmd w_cmd;

    // The controller owns both handshakes and issues one command per item of a known kind.
    wsrm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_kind),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    // The datapath holds the pattern, the match row and the result register.
    wsrm_dp #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_position     (i_position),
        .i_symbol       (i_symbol),
        .i_pattern_last (i_pattern_last),
        .o_matched      (o_matched)
    );

`ifndef SYNTHESIS
    // An accepted end-of-text item always leaves a result waiting.
    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_kind == KIND_END) |=> o_out_valid)
        else $error("end-of-text item accepted without a following result");

    // A held result that is not taken blocks further intake.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while a result is stalled");

    // A result only ever follows an accepted end-of-text item.
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready && i_kind == KIND_END))
        else $error("result appeared without an end-of-text item");

    // Only a finish command may change the held result bit.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(w_cmd.finish) && $past(o_out_valid) |-> $stable(o_matched))
        else $error("held result changed without a new end-of-text item");
`endif

endmodule
